// File: src/ue2u_pkg.sv
// Shared types, constants and helper functions of the unicode escape to UTF-8 decoder.
`timescale 1ns / 1ps
`default_nettype none
package ue2u_pkg;

    localparam logic [7:0] ESC_SLASH = 8'h5C;
    localparam logic [7:0] ESC_U     = 8'h75;

    localparam int HELD_DEPTH  = 5;
    localparam int MAX_RUN     = HELD_DEPTH + 1;
    localparam int RUN_CNT_W   = $clog2(MAX_RUN + 1);
    localparam int QUEUE_DEPTH = 2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]    cnt;
        logic                    last;
    } run_t;

    function automatic logic hex_ok(input byte_t b);
        hex_ok = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
              || (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input byte_t b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            v = b[3:0] + 4'd9;
        end
        hex_val = v;
    endfunction

endpackage
`default_nettype wire

// File: src/unicode_escape_to_utf8.sv
// Top level of the backslash-u escape to UTF-8 stream decoder.
//
//  channel | signals                                    | handshake
//  --------+--------------------------------------------+-----------------------
//  in      | in_byte[7:0], in_last                      | in_valid / in_ready
//  out     | out_byte[7:0], out_run_last, out_text_end  | out_valid / out_ready
//
// One input item is accepted per cycle while the run queue has room.
// The serializer sends one byte per cycle unless out_ready stalls the output;
// a byte passes through the run queue, the current-run register and the output
// register. Reset clears the matcher, queue and output stage at once.
// in_ready drops only when the run queue is full.
`timescale 1ns / 1ps
`default_nettype none
module unicode_escape_to_utf8
    import ue2u_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_run_last,
    output logic            out_text_end
);

    run_t front_run;
    run_t q_data;
    logic push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    ue2u_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (in_byte),
        .in_last (in_last),
        .run     (front_run),
        .push    (push)
    );

    ue2u_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_run),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_data),
        .valid (q_valid)
    );

    ue2u_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .out_run_last (out_run_last),
        .out_text_end (out_text_end)
    );

endmodule
`default_nettype wire

// File: src/ue2u_front.sv
// Front end: escape matcher that turns accepted items into runs of result bytes.
`timescale 1ns / 1ps
`default_nettype none
module ue2u_front
    import ue2u_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  take,
    input  wire byte_t in_byte,
    input  wire logic  in_last,
    output run_t       run,
    output logic       push
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_SLASH = 3'd1,
        ST_U     = 3'd2,
        ST_H1    = 3'd3,
        ST_H2    = 3'd4,
        ST_H3    = 3'd5
    } stage_t;

    stage_t stage_reg, stage_next;
    byte_t  held_reg [HELD_DEPTH];

    logic                 is_hex;
    logic                 cont;
    logic                 complete;
    logic [2:0]           st_cnt;
    logic                 wr_en;
    logic [2:0]           wr_idx;
    logic [15:0]          cp;
    run_t                 run_c;

    always_comb
    begin
        is_hex   = hex_ok(in_byte);
        st_cnt   = stage_reg;
        complete = (stage_reg == ST_H3) && is_hex;
        cp       = {hex_val(held_reg[2]), hex_val(held_reg[3]),
                    hex_val(held_reg[4]), hex_val(in_byte)};

        case (stage_reg)
            ST_IDLE:  cont = (in_byte == ESC_SLASH);
            ST_SLASH: cont = (in_byte == ESC_U);
            ST_U:     cont = is_hex;
            ST_H1:    cont = is_hex;
            ST_H2:    cont = is_hex;
            ST_H3:    cont = is_hex;
            default:  cont = (in_byte == ESC_SLASH);
        endcase

        for (int k = 0; k < HELD_DEPTH; k++) begin
            run_c.bytes[k] = (3'(k) < st_cnt) ? held_reg[k] : in_byte;
        end
        run_c.bytes[MAX_RUN-1] = in_byte;
        run_c.last = in_last;
        run_c.cnt  = '0;
        stage_next = stage_reg;
        wr_en      = 1'b0;
        wr_idx     = st_cnt;

        if (complete) begin
            stage_next = ST_IDLE;
            if (cp[15:7] == '0) begin
                run_c.bytes[0] = cp[7:0];
                run_c.cnt      = RUN_CNT_W'(1);
            end
            else if (cp[15:11] == '0) begin
                run_c.bytes[0] = {3'b110, cp[10:6]};
                run_c.bytes[1] = {2'b10, cp[5:0]};
                run_c.cnt      = RUN_CNT_W'(2);
            end
            else begin
                run_c.bytes[0] = {4'b1110, cp[15:12]};
                run_c.bytes[1] = {2'b10, cp[11:6]};
                run_c.bytes[2] = {2'b10, cp[5:0]};
                run_c.cnt      = RUN_CNT_W'(3);
            end
        end
        else if (cont && !in_last) begin
            wr_en = 1'b1;
            case (stage_reg)
                ST_IDLE:  stage_next = ST_SLASH;
                ST_SLASH: stage_next = ST_U;
                ST_U:     stage_next = ST_H1;
                ST_H1:    stage_next = ST_H2;
                ST_H2:    stage_next = ST_H3;
                default:  stage_next = ST_IDLE;
            endcase
        end
        else if (!cont && (in_byte == ESC_SLASH) && !in_last) begin
            run_c.cnt  = RUN_CNT_W'(st_cnt);
            wr_en      = 1'b1;
            wr_idx     = 3'd0;
            stage_next = ST_SLASH;
        end
        else begin
            run_c.cnt  = RUN_CNT_W'({1'b0, st_cnt} + 4'd1);
            stage_next = ST_IDLE;
        end
    end

    assign run  = run_c;
    assign push = take && (run_c.cnt != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_reg <= ST_IDLE;
        end
        else if (take) begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && wr_en) begin
            held_reg[wr_idx] <= in_byte;
        end
    end

endmodule
`default_nettype wire

// File: src/ue2u_queue.sv
// Short run queue between the matcher and the byte serializer.
`timescale 1ns / 1ps
`default_nettype none
module ue2u_queue
    import ue2u_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire run_t wdata,
    output logic      full,
    input  wire logic pop,
    output run_t      rdata,
    output logic      valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    run_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign valid   = (cnt_reg != '0);
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// File: src/ue2u_back.sv
// Back end: serializes queued runs into one output byte per cycle unless out_ready stalls the output.
`timescale 1ns / 1ps
`default_nettype none
module ue2u_back
    import ue2u_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire run_t  q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  wire logic  out_ready,
    output byte_t      out_byte,
    output logic       out_run_last,
    output logic       out_text_end
);

    logic [MAX_RUN-1:0][7:0] cur_bytes_reg, cur_bytes_next;
    logic [RUN_CNT_W-1:0]    cur_cnt_reg, cur_cnt_next;
    logic                    cur_last_reg, cur_last_next;
    logic                    out_valid_reg, out_valid_next;
    byte_t                   out_byte_reg, out_byte_next;
    logic                    out_run_last_reg, out_run_last_next;
    logic                    out_text_end_reg, out_text_end_next;
    logic                    load_out;
    logic                    final_byte;

    always_comb
    begin
        load_out   = (cur_cnt_reg != '0) && (!out_valid_reg || out_ready);
        final_byte = (cur_cnt_reg == RUN_CNT_W'(1));
        q_pop      = q_valid && ((cur_cnt_reg == '0) || (load_out && final_byte));

        cur_bytes_next    = cur_bytes_reg;
        cur_cnt_next      = cur_cnt_reg;
        cur_last_next     = cur_last_reg;
        out_valid_next    = out_valid_reg;
        out_byte_next     = out_byte_reg;
        out_run_last_next = out_run_last_reg;
        out_text_end_next = out_text_end_reg;

        if (load_out) begin
            out_valid_next    = 1'b1;
            out_byte_next     = cur_bytes_reg[0];
            out_run_last_next = final_byte;
            out_text_end_next = final_byte && cur_last_reg;
            for (int k = 0; k < MAX_RUN - 1; k++) begin
                cur_bytes_next[k] = cur_bytes_reg[k+1];
            end
            cur_cnt_next = cur_cnt_reg - RUN_CNT_W'(1);
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end

        if (q_pop) begin
            cur_bytes_next = q_data.bytes;
            cur_cnt_next   = q_data.cnt;
            cur_last_next  = q_data.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            cur_cnt_reg   <= cur_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_bytes_reg    <= cur_bytes_next;
        cur_last_reg     <= cur_last_next;
        out_byte_reg     <= out_byte_next;
        out_run_last_reg <= out_run_last_next;
        out_text_end_reg <= out_text_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_run_last = out_run_last_reg;
    assign out_text_end = out_text_end_reg;

endmodule
`default_nettype wire

// File: src/ue2u_checker.sv
// Port-level assertions for the decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ue2u_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [7:0] in_byte,
    input wire logic       in_last,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       out_run_last,
    input wire logic       out_text_end
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
        else $error("input item changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_run_last) && $stable(out_text_end))
        else $error("output item changed while stalled");

    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_text_end |-> out_run_last)
        else $error("text end flagged inside a run");

    a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_run_last |=> out_valid)
        else $error("gap inside an output run");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind unicode_escape_to_utf8 ue2u_checker u_ue2u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
);
`default_nettype wire
